FILE: sv/itr_pkg.sv
package itr_pkg;

    // rotation matrix entries (row major, q2.30) and moments (q16.16)
    typedef struct packed {
        logic [8:0][31:0] rot;
        logic [2:0][31:0] mom;
    } t_mid;

    // tensor entries out of the back end
    typedef struct packed {
        logic [5:0][35:0] ten;
    } t_res;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // row and column of each distinct tensor entry: xx xy xz yy yz zz
    localparam int ENT_I [6] = '{0, 0, 0, 1, 1, 2};
    localparam int ENT_J [6] = '{0, 1, 2, 1, 2, 2};

endpackage

FILE: sv/itr_front.sv
module itr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic signed [15:0]   i_quat_w,
    input  logic signed [15:0]   i_quat_x,
    input  logic signed [15:0]   i_quat_y,
    input  logic signed [15:0]   i_quat_z,
    input  logic [31:0]          i_moment_a,
    input  logic [31:0]          i_moment_b,
    input  logic [31:0]          i_moment_c,
    output logic                 o_valid,
    input  logic                 i_ready,
    output itr_pkg::t_mid        o_data
);

    localparam logic signed [34:0] ONE_Q30 = 35'sd1073741824;
    localparam logic signed [34:0] R_MAX   = 35'sd2147483647;
    localparam logic signed [34:0] R_MIN   = -35'sd2147483648;

    function automatic logic signed [34:0] sx(input logic signed [31:0] v);
        sx = {{3{v[31]}}, v};
    endfunction

    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        logic signed [34:0] c;
        c = (v > R_MAX) ? R_MAX : ((v < R_MIN) ? R_MIN : v);
        sat32 = c[31:0];
    endfunction

    logic r_v1, r_v2;
    logic signed [31:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic [2:0][31:0] r_mom1;
    itr_pkg::t_mid r_out, n_out;
    logic rdy1, rdy2;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_full  = !rdy1;
    assign o_valid = r_v2;
    assign o_data  = r_out;

    // valid bits of the two stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_push;
            if (rdy2) r_v2 <= r_v1;
        end
    end

    // stage one: quaternion component products
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_push) begin
            r_xx   <= i_quat_x * i_quat_x;
            r_yy   <= i_quat_y * i_quat_y;
            r_zz   <= i_quat_z * i_quat_z;
            r_xy   <= i_quat_x * i_quat_y;
            r_xz   <= i_quat_x * i_quat_z;
            r_yz   <= i_quat_y * i_quat_z;
            r_wx   <= i_quat_w * i_quat_x;
            r_wy   <= i_quat_w * i_quat_y;
            r_wz   <= i_quat_w * i_quat_z;
            r_mom1 <= {i_moment_c, i_moment_b, i_moment_a};
        end
    end

    // stage two: rotation matrix entries, saturated to q2.30
    always_comb begin
        n_out.rot[0] = sat32(ONE_Q30 - 35'sd2 * (sx(r_yy) + sx(r_zz)));
        n_out.rot[1] = sat32(35'sd2 * (sx(r_xy) - sx(r_wz)));
        n_out.rot[2] = sat32(35'sd2 * (sx(r_xz) + sx(r_wy)));
        n_out.rot[3] = sat32(35'sd2 * (sx(r_xy) + sx(r_wz)));
        n_out.rot[4] = sat32(ONE_Q30 - 35'sd2 * (sx(r_xx) + sx(r_zz)));
        n_out.rot[5] = sat32(35'sd2 * (sx(r_yz) - sx(r_wx)));
        n_out.rot[6] = sat32(35'sd2 * (sx(r_xz) - sx(r_wy)));
        n_out.rot[7] = sat32(35'sd2 * (sx(r_yz) + sx(r_wx)));
        n_out.rot[8] = sat32(ONE_Q30 - 35'sd2 * (sx(r_xx) + sx(r_yy)));
        n_out.mom    = r_mom1;
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) r_out <= n_out;
    end

endmodule

FILE: sv/itr_fifo.sv
module itr_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  itr_pkg::t_mid i_data,
    input  logic          i_pop,
    output logic          o_empty,
    output itr_pkg::t_mid o_data
);

    localparam logic [itr_pkg::FIFO_AW:0] DEPTH = (itr_pkg::FIFO_AW + 1)'(itr_pkg::FIFO_DEPTH);

    itr_pkg::t_mid r_mem [itr_pkg::FIFO_DEPTH];
    logic [itr_pkg::FIFO_AW-1:0] r_wp, r_rp;
    logic [itr_pkg::FIFO_AW:0]   r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == DEPTH);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule

FILE: sv/itr_back.sv
module itr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  itr_pkg::t_mid i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output itr_pkg::t_res o_data
);

    localparam logic signed [38:0] T_MAX = 39'sd34359738367;
    localparam logic signed [38:0] T_MIN = -39'sd34359738368;

    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;
    logic [17:0][31:0] r_p, n_p;
    logic [2:0][31:0]  r_mom;
    logic [17:0][36:0] r_q, n_q;
    itr_pkg::t_res     r_res, n_res;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v3;
    assign o_data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    // stage one: matrix entry pair products floored to q4.28
    always_comb begin
        logic signed [63:0] pr;
        for (int e = 0; e < 6; e++) begin
            for (int k = 0; k < 3; k++) begin
                pr = $signed(i_data.rot[itr_pkg::ENT_I[e]*3+k])
                   * $signed(i_data.rot[itr_pkg::ENT_J[e]*3+k]);
                n_p[e*3+k] = pr[63:32];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_p   <= n_p;
            r_mom <= i_data.mom;
        end
    end

    // stage two: times moment, floored to q.16
    always_comb begin
        logic signed [64:0] qr;
        for (int e = 0; e < 6; e++) begin
            for (int k = 0; k < 3; k++) begin
                qr = $signed({r_p[e*3+k][31], r_p[e*3+k]}) * $signed({1'b0, r_mom[k]});
                n_q[e*3+k] = qr[64:28];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) r_q <= n_q;
    end

    // stage three: sum of three terms, saturated to q20.16
    always_comb begin
        logic signed [38:0] s;
        for (int e = 0; e < 6; e++) begin
            s = $signed({{2{r_q[e*3][36]}}, r_q[e*3]})
              + $signed({{2{r_q[e*3+1][36]}}, r_q[e*3+1]})
              + $signed({{2{r_q[e*3+2][36]}}, r_q[e*3+2]});
            if (s > T_MAX)      s = T_MAX;
            else if (s < T_MIN) s = T_MIN;
            n_res.ten[e] = s[35:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) r_res <= n_res;
    end

endmodule

FILE: sv/inertia_tensor_rotate_top.sv
// channel | handshake        | beat
// input   | i_push / o_full  | quaternion w x y z, moments a b c
// result  | o_empty / i_pop  | six tensor entries xx xy xz yy yz zz
//
// one beat per cycle sustained while results are popped; every multiplier stage is pipelined
// a pushed beat passes the front stage registers, the queue and the back stage registers
// a four-entry queue sits between the matrix front end and the tensor back end
// synchronous active-low reset empties both pipelines and the queue
// a stalled result holds its value; the input side keeps going until back end, queue and front end fill
module inertia_tensor_rotate_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic signed [15:0]   i_quat_w,
    input  logic signed [15:0]   i_quat_x,
    input  logic signed [15:0]   i_quat_y,
    input  logic signed [15:0]   i_quat_z,
    input  logic [31:0]          i_moment_a,
    input  logic [31:0]          i_moment_b,
    input  logic [31:0]          i_moment_c,
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic signed [35:0]   o_tensor_xx,
    output logic signed [35:0]   o_tensor_xy,
    output logic signed [35:0]   o_tensor_xz,
    output logic signed [35:0]   o_tensor_yy,
    output logic signed [35:0]   o_tensor_yz,
    output logic signed [35:0]   o_tensor_zz
);

    logic          f_valid, q_full, q_empty, b_ready, b_valid;
    itr_pkg::t_mid f_data, q_data;
    itr_pkg::t_res b_data;

    itr_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full,
        .i_quat_w, .i_quat_x, .i_quat_y, .i_quat_z,
        .i_moment_a, .i_moment_b, .i_moment_c,
        .o_valid (f_valid), .i_ready (!q_full), .o_data (f_data)
    );

    itr_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_push (f_valid), .o_full (q_full), .i_data (f_data),
        .i_pop (b_ready), .o_empty (q_empty), .o_data (q_data)
    );

    itr_back u_back (
        .i_clk, .i_rst_n,
        .i_valid (!q_empty), .o_ready (b_ready), .i_data (q_data),
        .o_valid (b_valid), .i_ready (i_pop), .o_data (b_data)
    );

    assign o_empty     = !b_valid;
    assign o_tensor_xx = b_data.ten[0];
    assign o_tensor_xy = b_data.ten[1];
    assign o_tensor_xz = b_data.ten[2];
    assign o_tensor_yy = b_data.ten[3];
    assign o_tensor_yz = b_data.ten[4];
    assign o_tensor_zz = b_data.ten[5];

endmodule

FILE: sv/itr_checker.sv
module itr_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_push,
    input logic                 o_full,
    input logic                 o_empty,
    input logic                 i_pop,
    input logic signed [35:0]   o_tensor_xx,
    input logic signed [35:0]   o_tensor_xy,
    input logic signed [35:0]   o_tensor_xz,
    input logic signed [35:0]   o_tensor_yy,
    input logic signed [35:0]   o_tensor_yz,
    input logic signed [35:0]   o_tensor_zz
);

    // reset leaves nothing to deliver and room to accept
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty && !o_full)
        else $error("not empty after reset");

    // no result without an earlier accepted beat
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_push && !o_full) && o_empty |=> o_empty || $past(!o_empty, 2)
            || $past(i_push, 2) || $past(i_push, 3) || $past(i_push, 4)
            || $past(i_push, 5) || $past(i_push, 6))
        else $error("result out of nowhere");

    // waiting result is not dropped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty)
        else $error("result lost while stalled");

    // stalled result keeps its payload
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> $stable(o_tensor_xx) && $stable(o_tensor_xy)
            && $stable(o_tensor_xz) && $stable(o_tensor_yy)
            && $stable(o_tensor_yz) && $stable(o_tensor_zz))
        else $error("stalled result changed");

endmodule

bind inertia_tensor_rotate_top itr_checker u_chk (.*);

FILE: dv/tb_inertia_tensor_rotate_top.sv
`timescale 1ns / 100ps

module tb_inertia_tensor_rotate_top;

    localparam int  N_RANDOM   = 700;
    localparam int  CYCLE_CAP  = 200000;
    localparam int  DRAIN_WAIT = 20;
    localparam int  N_DIRECTED = 16;

    localparam logic [31:0]        MOM_ONE = 32'h0001_0000;
    localparam logic signed [15:0] Q_POS   = 16'sh7FFF;
    localparam logic signed [15:0] Q_NEG   = 16'sh8000;

    typedef struct {
        logic signed [15:0] qw, qx, qy, qz;
        logic [31:0]        ma, mb, mc;
    } t_beat_in;

    typedef struct {
        logic signed [35:0] xx, xy, xz, yy, yz, zz;
    } t_tensor;

    // directed row: input beat plus an optional hand-typed tensor
    typedef struct {
        t_beat_in bin;
        bit       typed;
        t_tensor  ten;
    } t_row;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic signed [15:0]  qw, qx, qy, qz;
    logic [31:0]         ma, mb, mc;
    logic                empty;
    logic                pop;
    logic signed [35:0]  t_xx, t_xy, t_xz, t_yy, t_yz, t_zz;

    t_tensor tensor_queue[$];
    t_row    rows[N_DIRECTED];
    int      err_count = 0;
    int      cycle_count = 0;
    bit      quiet_tail;

    inertia_tensor_rotate_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_quat_w    (qw),
        .i_quat_x    (qx),
        .i_quat_y    (qy),
        .i_quat_z    (qz),
        .i_moment_a  (ma),
        .i_moment_b  (mb),
        .i_moment_c  (mc),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_tensor_xx (t_xx),
        .o_tensor_xy (t_xy),
        .o_tensor_xz (t_xz),
        .o_tensor_yy (t_yy),
        .o_tensor_yz (t_yz),
        .o_tensor_zz (t_zz)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // floor division by 2^s for signed values
    function automatic logic signed [127:0] shr_floor(logic signed [127:0] v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [127:0] sat(logic signed [127:0] v,
                                                logic signed [127:0] lo,
                                                logic signed [127:0] hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // rotate diag moments by the quaternion matrix
    function automatic t_tensor rotate_tensor(t_beat_in b);
        logic signed [127:0] w, x, y, z, one, s, p;
        logic signed [127:0] rm[3][3];
        logic signed [127:0] mv[3];
        logic signed [35:0]  e[6];
        int                  ei[6];
        int                  ej[6];
        t_tensor             t;
        w = b.qw; x = b.qx; y = b.qy; z = b.qz;
        one = 128'sd1 <<< 30;
        mv[0] = {96'd0, b.ma};
        mv[1] = {96'd0, b.mb};
        mv[2] = {96'd0, b.mc};
        rm[0][0] = one - 2 * (y * y + z * z);
        rm[0][1] = 2 * (x * y - w * z);
        rm[0][2] = 2 * (x * z + w * y);
        rm[1][0] = 2 * (x * y + w * z);
        rm[1][1] = one - 2 * (x * x + z * z);
        rm[1][2] = 2 * (y * z - w * x);
        rm[2][0] = 2 * (x * z - w * y);
        rm[2][1] = 2 * (y * z + w * x);
        rm[2][2] = one - 2 * (x * x + y * y);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                rm[i][j] = sat(rm[i][j], -(128'sd1 <<< 31), (128'sd1 <<< 31) - 1);
        ei = '{0, 0, 0, 1, 1, 2};
        ej = '{0, 1, 2, 1, 2, 2};
        for (int n = 0; n < 6; n++) begin
            s = 0;
            for (int k = 0; k < 3; k++) begin
                p = shr_floor(rm[ei[n]][k] * rm[ej[n]][k], 32);
                s = s + shr_floor(p * mv[k], 28);
            end
            e[n] = 36'(sat(s, -(128'sd1 <<< 35), (128'sd1 <<< 35) - 1));
        end
        t.xx = e[0]; t.xy = e[1]; t.xz = e[2];
        t.yy = e[3]; t.yz = e[4]; t.zz = e[5];
        return t;
    endfunction

    function automatic t_beat_in mk_beat(logic signed [15:0] w, x, y, z,
                                         logic [31:0] a, b, c);
        t_beat_in r;
        r.qw = w; r.qx = x; r.qy = y; r.qz = z;
        r.ma = a; r.mb = b; r.mc = c;
        return r;
    endfunction

    function automatic t_tensor mk_ten(logic signed [35:0] xx, xy, xz, yy, yz, zz);
        t_tensor t;
        t.xx = xx; t.xy = xy; t.xz = xz; t.yy = yy; t.yz = yz; t.zz = zz;
        return t;
    endfunction

    function automatic logic [31:0] rand_moment();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 32'h00FF_FFFF);
            2:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: return $urandom_range(0, 32'h0100_0000);
        endcase
    endfunction

    // mostly halved random quaternions, some raw noise
    function automatic t_beat_in rand_beat();
        t_beat_in b;
        int       pick;
        pick = $urandom_range(0, 9);
        b.qw = 16'($urandom); b.qx = 16'($urandom);
        b.qy = 16'($urandom); b.qz = 16'($urandom);
        if (pick < 6) begin
            b.qw = $signed(b.qw) >>> 1;
            b.qx = $signed(b.qx) >>> 1;
            b.qy = $signed(b.qy) >>> 1;
            b.qz = $signed(b.qz) >>> 1;
        end
        b.ma = rand_moment();
        b.mb = rand_moment();
        b.mc = rand_moment();
        return b;
    endfunction

    // directed table
    initial begin
        t_tensor z6;
        z6 = mk_ten(0, 0, 0, 0, 0, 0);
        // identity rotation, unit moments
        rows[0]  = '{mk_beat(Q_POS, 0, 0, 0, MOM_ONE, MOM_ONE, MOM_ONE), 1'b1,
                     mk_ten(36'sh1_0000, 0, 0, 36'sh1_0000, 0, 36'sh1_0000)};
        // zero quaternion, zero moments
        rows[1]  = '{mk_beat(0, 0, 0, 0, 0, 0, 0), 1'b1, z6};
        // zero quaternion keeps identity matrix; max moments pass through
        rows[2]  = '{mk_beat(0, 0, 0, 0, '1, '1, '1), 1'b1,
                     mk_ten(36'sh0_FFFF_FFFF, 0, 0, 36'sh0_FFFF_FFFF, 0, 36'sh0_FFFF_FFFF)};
        rows[3]  = '{mk_beat(Q_NEG, Q_NEG, Q_NEG, Q_NEG, '1, '1, '1), 1'b0, z6};
        rows[4]  = '{mk_beat(Q_POS, Q_POS, Q_POS, Q_POS, '1, '1, '1), 1'b0, z6};
        rows[5]  = '{mk_beat(Q_NEG, Q_POS, Q_NEG, Q_POS, '1, 0, '1), 1'b0, z6};
        rows[6]  = '{mk_beat(0, Q_POS, 0, 0, MOM_ONE, 32'h0002_0000, 32'h0003_0000),
                     1'b0, z6};
        rows[7]  = '{mk_beat(0, 0, Q_NEG, 0, MOM_ONE, 32'h0002_0000, 32'h0003_0000),
                     1'b0, z6};
        rows[8]  = '{mk_beat(0, 0, 0, Q_POS, 32'h1234_5678, 32'h9ABC_DEF0, 1), 1'b0, z6};
        rows[9]  = '{mk_beat(16'sh5A82, 16'sh5A82, 0, 0, '1, 0, 0), 1'b0, z6};
        rows[10] = '{mk_beat(16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000, 1, '1, 1),
                     1'b0, z6};
        rows[11] = '{mk_beat(16'sh4000, -16'sh4000, 16'sh4000, -16'sh4000, '1, 1, '1),
                     1'b0, z6};
        rows[12] = '{mk_beat(-1, -1, -1, -1, 32'h5555_5555, 32'hAAAA_AAAA, 1), 1'b0, z6};
        rows[13] = '{mk_beat(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
                             32'hAAAA_AAAA, 32'h5555_5555, '1), 1'b0, z6};
        rows[14] = '{mk_beat(Q_POS, Q_NEG, 0, Q_POS, 0, '1, 32'h8000_0000), 1'b0, z6};
        rows[15] = '{mk_beat(1, 1, 1, 1, 1, 1, 1), 1'b0, z6};
    end

    // abort on runaway
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("%0t timeout", $time);
            $display("tb_inertia_tensor_rotate_top: done, errors");
            $finish;
        end
    end

    // push one beat, with random idle bursts ahead of it
    task automatic send_beat(t_beat_in b, bit typed, t_tensor want);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        qw <= b.qw; qx <= b.qx; qy <= b.qy; qz <= b.qz;
        ma <= b.ma; mb <= b.mb; mc <= b.mc;
        @(posedge clk);
        while (full) @(posedge clk);
        tensor_queue = {tensor_queue, (typed ? want : rotate_tensor(b))};
    endtask

    // result side: random pop bursts, compare on accept
    always @(posedge clk) begin
        t_tensor want;
        int      bad;
        bad = 0;
        if (rst_n && pop && !empty) begin
            if (tensor_queue.size() == 0) begin
                $display("%0t unexpected beat xx=%0d", $time, t_xx);
                bad++;
            end else begin
                want = tensor_queue.pop_front();
                if (want.xx !== t_xx) begin
                    $display("%0t xx exp %0d got %0d", $time, want.xx, t_xx);
                    bad++;
                end
                if (want.xy !== t_xy) begin
                    $display("%0t xy exp %0d got %0d", $time, want.xy, t_xy);
                    bad++;
                end
                if (want.xz !== t_xz) begin
                    $display("%0t xz exp %0d got %0d", $time, want.xz, t_xz);
                    bad++;
                end
                if (want.yy !== t_yy) begin
                    $display("%0t yy exp %0d got %0d", $time, want.yy, t_yy);
                    bad++;
                end
                if (want.yz !== t_yz) begin
                    $display("%0t yz exp %0d got %0d", $time, want.yz, t_yz);
                    bad++;
                end
                if (want.zz !== t_zz) begin
                    $display("%0t zz exp %0d got %0d", $time, want.zz, t_zz);
                    bad++;
                end
            end
        end
        if (bad != 0) err_count <= err_count + bad;
    end

    // pop stall bursts
    initial begin
        pop = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end else begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // main sequence
    initial begin
        int wait_cnt;
        t_tensor dummy;
        rst_n = 1'b0;
        push = 1'b0;
        qw = 0; qx = 0; qy = 0; qz = 0;
        ma = 0; mb = 0; mc = 0;
        quiet_tail = 1'b0;
        dummy = mk_ten(0, 0, 0, 0, 0, 0);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIRECTED; r++)
            send_beat(rows[r].bin, rows[r].typed, rows[r].ten);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 100) quiet_tail = 1'b1;
            send_beat(rand_beat(), 1'b0, dummy);
        end
        push <= 1'b0;

        while (tensor_queue.size() != 0) @(posedge clk);
        wait_cnt = 0;
        while (wait_cnt < DRAIN_WAIT) begin
            @(posedge clk);
            wait_cnt++;
        end
        if (err_count == 0 && tensor_queue.size() == 0)
            $display("tb_inertia_tensor_rotate_top: done, clean");
        else
            $display("tb_inertia_tensor_rotate_top: done, errors");
        $finish;
    end

endmodule

FILE: inertia_tensor_rotate_top.f
sv/itr_pkg.sv
sv/itr_front.sv
sv/itr_fifo.sv
sv/itr_back.sv
sv/inertia_tensor_rotate_top.sv
sv/itr_checker.sv
dv/tb_inertia_tensor_rotate_top.sv
